>>> hw/rtl/skf_pkg.sv
`timescale 1ns / 1ps

package skf_pkg;

	// Fixed-point and field widths.
	localparam int GAIN_FRAC_BITS = 24;
	localparam int SAMPLE_BITS    = 16;
	localparam int GAIN_W         = GAIN_FRAC_BITS + 1;  // gain never exceeds 1.0
	localparam int COEF_W         = 8;                   // A, B, H
	localparam int NOISE_W        = 16;                  // Cu, Cw, start variance
	localparam int VAR_W          = 31;
	localparam int VAL_W          = 32;
	localparam int HP_W           = VAR_W + COEF_W;      // H*P
	localparam int DEN_W          = HP_W + COEF_W + 1;   // H*H*P + Cw
	localparam int HX_W           = VAL_W + COEF_W;      // H*|x|
	localparam int INNOV_W        = HX_W + 1;            // signed innovation
	localparam int ACC_W          = 64;                  // multiplier accumulator
	localparam int DIV_CNT_W      = $clog2(GAIN_W + 1);
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;
	localparam logic [VAR_W-1:0]  VAR_MAX  = '1;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_STATE_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_VAR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_VAR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_VAR    = 3'd5;

	// Register reset values.
	localparam logic [COEF_W-1:0]  RST_STATE_GAIN   = 8'd1;
	localparam logic [COEF_W-1:0]  RST_NOISE_GAIN   = 8'd1;
	localparam logic [COEF_W-1:0]  RST_MEASURE_GAIN = 8'd1;
	localparam logic [NOISE_W-1:0] RST_PROCESS_VAR  = 16'd1;
	localparam logic [NOISE_W-1:0] RST_MEASURE_VAR  = 16'd4;
	localparam logic [NOISE_W-1:0] RST_START_VAR    = 16'd1;

	// Sequencer steps, one per arithmetic operation.
	typedef enum logic [3:0] {
		S_IDLE,
		S_HP,    // H * P
		S_DEN,   // H * (H*P), then + Cw
		S_HX,    // H * |x_pred|, then innovation
		S_DIV,   // gain by restoring division
		S_CORR,  // |innovation| * K, then corrected sum
		S_EST,   // truncate and clamp the estimate
		S_KH,    // K * H, then 1.0 - K*H
		S_PEST,  // (1.0 - K*H) * P
		S_AX,    // A * |estimate|
		S_AP,    // A * Pest
		S_AAP,   // A * (A*Pest)
		S_BC,    // B * Cu
		S_BBC,   // B * (B*Cu)
		S_OUT    // time update and result
	} state_t;

endpackage

>>> hw/rtl/scalar_kalman_filter_unit.sv
`timescale 1ns / 1ps

// Scalar Kalman filter. Each measurement transaction on the slave stream yields one
// estimate transaction on the master stream, and the filter state (predicted value and
// predicted variance) is advanced once per measurement. All arithmetic runs through one
// shift-add multiplier that consumes one multiplier bit per cycle and one restoring
// divider that produces one gain bit per cycle. Besides the accept and result steps, an
// item takes eleven multiplications, each of which loads its operands, works through
// the 8-bit or 25-bit multiplier operand bit by bit and closes (they end early when the
// remaining multiplier bits are zero), one gain division and one estimate clamp. The
// result step stretches while the output register still holds a transaction that the
// consumer has not taken.
// A new measurement is taken once the previous one has moved into the output register,
// even while that result still waits for the consumer. Configuration writes must only
// be issued while the block is idle; writing the start variance also reloads the
// predicted variance. Any clamp of the estimate, the predicted value or the predicted
// variance sets the saturated flag of that result.

module scalar_kalman_filter_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [skf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [skf_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,   // [15:0] measurement
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [31:0]                      m_tdata,   // [31:0] estimate
	output logic                             m_tuser    // [0] saturated
);

	localparam int SB = skf_pkg::SAMPLE_BITS;
	localparam int F  = skf_pkg::GAIN_FRAC_BITS;
	localparam int GW = skf_pkg::GAIN_W;
	localparam int AW = skf_pkg::ACC_W;
	localparam int DW = skf_pkg::DEN_W;
	localparam int VW = skf_pkg::VAL_W;
	localparam int IW = skf_pkg::INNOV_W;

	skf_pkg::state_t state_q, state_next;

	// Configuration registers and filter state.
	logic [skf_pkg::COEF_W-1:0]  a_q, b_q, h_q;
	logic [skf_pkg::NOISE_W-1:0] cu_q, cw_q;
	logic [VW-1:0]               x_q;
	logic [skf_pkg::VAR_W-1:0]   p_q;

	// Per-item working registers.
	logic [SB-1:0]               y_q;
	logic [skf_pkg::HP_W-1:0]    hp_q;
	logic [DW-1:0]               den_q;
	logic                        innov_neg_q;
	logic [IW-2:0]               innov_mag_q;
	logic [AW-1:0]               total_q;
	logic                        est_neg_q;
	logic [VW-1:0]               est_mag_q;
	logic [GW-1:0]               d_q;
	logic [skf_pkg::VAR_W-1:0]   pest_q;
	logic [VW-1:0]               xn_q;
	logic [DW-1:0]               aap_q;
	logic                        sat_q;
	logic                        ld_q;

	// Shift-add multiplier.
	logic [AW-1:0] mc_q, acc_q;
	logic [GW-1:0] mp_q;

	// Restoring divider.
	logic [DW:0]                     rem_q;
	logic [GW-1:0]                   quo_q;
	logic [skf_pkg::DIV_CNT_W-1:0]   div_cnt_q;

	// Output register.
	logic          m_tvalid_q, m_tuser_q;
	logic [VW-1:0] m_tdata_q;

	// Sequencer outputs.
	logic          is_mul, mul_load, mul_done, div_done, step_done, out_free, out_load;
	logic [AW-1:0] mc_sel;
	logic [GW-1:0] mp_sel;

	// Datapath temporaries.
	logic [VW-1:0] x_mag;
	logic [IW-1:0] y_ext, hx_ext, innov;
	logic [AW-1:0] corr, total, t_mag, t_shr, t_lim, ax_lim;
	logic          t_over, ax_over;
	logic [GW-1:0] kh_clamped;
	logic [DW:0]   div_try, p_next;
	logic          div_ge;

	assign x_mag = x_q[VW-1] ? (~x_q + VW'(1)) : x_q;

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			skf_pkg::S_IDLE: if (step_done) state_next = skf_pkg::S_HP;
			skf_pkg::S_HP:   if (step_done) state_next = skf_pkg::S_DEN;
			skf_pkg::S_DEN:  if (step_done) state_next = skf_pkg::S_HX;
			skf_pkg::S_HX:   if (step_done) state_next = skf_pkg::S_DIV;
			skf_pkg::S_DIV:  if (step_done) state_next = skf_pkg::S_CORR;
			skf_pkg::S_CORR: if (step_done) state_next = skf_pkg::S_EST;
			skf_pkg::S_EST:  if (step_done) state_next = skf_pkg::S_KH;
			skf_pkg::S_KH:   if (step_done) state_next = skf_pkg::S_PEST;
			skf_pkg::S_PEST: if (step_done) state_next = skf_pkg::S_AX;
			skf_pkg::S_AX:   if (step_done) state_next = skf_pkg::S_AP;
			skf_pkg::S_AP:   if (step_done) state_next = skf_pkg::S_AAP;
			skf_pkg::S_AAP:  if (step_done) state_next = skf_pkg::S_BC;
			skf_pkg::S_BC:   if (step_done) state_next = skf_pkg::S_BBC;
			skf_pkg::S_BBC:  if (step_done) state_next = skf_pkg::S_OUT;
			skf_pkg::S_OUT:  if (step_done) state_next = skf_pkg::S_IDLE;
			default:         state_next = skf_pkg::S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- sequencer outputs
	// Each multiply step names its multiplicand and its multiplier; the multiplier
	// is shifted out one bit per cycle.
	always_comb begin
		is_mul = 1'b1;
		mc_sel = '0;
		mp_sel = '0;
		unique case (state_q)
			skf_pkg::S_HP:   begin mc_sel = AW'(p_q);         mp_sel = GW'(h_q); end
			skf_pkg::S_DEN:  begin mc_sel = AW'(hp_q);        mp_sel = GW'(h_q); end
			skf_pkg::S_HX:   begin mc_sel = AW'(x_mag);       mp_sel = GW'(h_q); end
			skf_pkg::S_CORR: begin mc_sel = AW'(innov_mag_q); mp_sel = quo_q;    end
			skf_pkg::S_KH:   begin mc_sel = AW'(quo_q);       mp_sel = GW'(h_q); end
			skf_pkg::S_PEST: begin mc_sel = AW'(p_q);         mp_sel = d_q;      end
			skf_pkg::S_AX:   begin mc_sel = AW'(est_mag_q);   mp_sel = GW'(a_q); end
			// The estimate variance was saved when its product finished.
			skf_pkg::S_AP:   begin mc_sel = AW'(pest_q);      mp_sel = GW'(a_q); end
			skf_pkg::S_AAP:  begin mc_sel = acc_q;            mp_sel = GW'(a_q); end
			skf_pkg::S_BC:   begin mc_sel = AW'(cu_q);        mp_sel = GW'(b_q); end
			skf_pkg::S_BBC:  begin mc_sel = acc_q;            mp_sel = GW'(b_q); end
			default:         is_mul = 1'b0;
		endcase

		mul_load = ld_q && is_mul;
		mul_done = !ld_q && (mp_q == '0);
		div_done = !ld_q && (div_cnt_q == skf_pkg::DIV_CNT_W'(GW));
		out_free = !m_tvalid_q || m_tready;
		s_tready = (state_q == skf_pkg::S_IDLE);

		unique case (state_q)
			skf_pkg::S_IDLE: step_done = s_tvalid;
			skf_pkg::S_DIV:  step_done = div_done;
			skf_pkg::S_EST:  step_done = 1'b1;
			skf_pkg::S_OUT:  step_done = out_free;
			default:         step_done = mul_done;
		endcase
		out_load = (state_q == skf_pkg::S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skf_pkg::S_IDLE;
			ld_q    <= 1'b0;
		end else begin
			state_q <= state_next;
			ld_q    <= (state_next != state_q);
		end
	end

	// ---------------------------------------------------------------- arithmetic helpers
	always_comb begin
		// Innovation y - H*x_pred, with H*|x_pred| in the accumulator.
		y_ext  = {{(IW-SB){y_q[SB-1]}}, y_q};
		hx_ext = IW'(acc_q[skf_pkg::HX_W-1:0]);
		innov  = x_q[VW-1] ? (y_ext + hx_ext) : (y_ext - hx_ext);

		// x_pred * 2^F plus the signed correction.
		corr  = innov_neg_q ? (~acc_q + AW'(1)) : acc_q;
		total = ({{(AW-VW){x_q[VW-1]}}, x_q} << F) + corr;

		// Truncation toward zero works on the magnitude; the negative limit is 2^31.
		t_mag  = total_q[AW-1] ? (~total_q + AW'(1)) : total_q;
		t_shr  = t_mag >> F;
		t_lim  = total_q[AW-1] ? (AW'(1) << (VW-1)) : ((AW'(1) << (VW-1)) - AW'(1));
		t_over = t_shr > t_lim;

		ax_lim  = est_neg_q ? (AW'(1) << (VW-1)) : ((AW'(1) << (VW-1)) - AW'(1));
		ax_over = acc_q > ax_lim;

		kh_clamped = (acc_q > AW'(skf_pkg::GAIN_ONE)) ? skf_pkg::GAIN_ONE : acc_q[GW-1:0];

		// One division step. The first step compares the numerator unshifted.
		div_try = (div_cnt_q == '0) ? rem_q : {rem_q[DW-1:0], 1'b0};
		div_ge  = (den_q != '0) && (div_try >= {1'b0, den_q});

		p_next = {1'b0, aap_q} + {1'b0, acc_q[DW-1:0]};
	end

	// ---------------------------------------------------------------- multiplier and divider
	always_ff @(posedge clk) begin
		if (mul_load) begin
			mc_q  <= mc_sel;
			mp_q  <= mp_sel;
			acc_q <= '0;
		end else if (is_mul && (mp_q != '0)) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end

		if (ld_q && (state_q == skf_pkg::S_DIV)) begin
			rem_q     <= (DW+1)'(hp_q);
			quo_q     <= '0;
			div_cnt_q <= '0;
		end else if ((state_q == skf_pkg::S_DIV) &&
				(div_cnt_q != skf_pkg::DIV_CNT_W'(GW))) begin
			rem_q     <= div_ge ? (div_try - {1'b0, den_q}) : div_try;
			quo_q     <= {quo_q[GW-2:0], div_ge};
			div_cnt_q <= div_cnt_q + skf_pkg::DIV_CNT_W'(1);
		end
	end

	// ---------------------------------------------------------------- step results
	always_ff @(posedge clk) begin
		if (state_q == skf_pkg::S_IDLE && s_tvalid) y_q <= s_tdata[SB-1:0];
		if (step_done) begin
			unique case (state_q)
				skf_pkg::S_HP:   hp_q  <= acc_q[skf_pkg::HP_W-1:0];
				skf_pkg::S_DEN:  den_q <= acc_q[DW-1:0] + DW'(cw_q);
				skf_pkg::S_HX: begin
					innov_neg_q <= innov[IW-1];
					innov_mag_q <= innov[IW-1] ? (~innov[IW-2:0] + (IW-1)'(1))
						: innov[IW-2:0];
				end
				skf_pkg::S_CORR: total_q <= total;
				skf_pkg::S_EST: begin
					est_neg_q <= total_q[AW-1];
					est_mag_q <= t_over ? t_lim[VW-1:0] : t_shr[VW-1:0];
				end
				skf_pkg::S_KH:   d_q <= skf_pkg::GAIN_ONE - kh_clamped;
				skf_pkg::S_PEST: pest_q <= acc_q[F +: skf_pkg::VAR_W];
				skf_pkg::S_AX: begin
					if (ax_over) xn_q <= est_neg_q ? (~ax_lim[VW-1:0] + VW'(1))
						: ax_lim[VW-1:0];
					else xn_q <= est_neg_q ? (~acc_q[VW-1:0] + VW'(1)) : acc_q[VW-1:0];
				end
				skf_pkg::S_AAP:  aap_q <= acc_q[DW-1:0];
				default: ;
			endcase
		end
		if (out_load) begin
			m_tdata_q <= est_neg_q ? (~est_mag_q + VW'(1)) : est_mag_q;
			m_tuser_q <= sat_q || (p_next > (DW+1)'(skf_pkg::VAR_MAX));
		end
	end

	// ---------------------------------------------------------------- control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q        <= skf_pkg::RST_STATE_GAIN;
			b_q        <= skf_pkg::RST_NOISE_GAIN;
			h_q        <= skf_pkg::RST_MEASURE_GAIN;
			cu_q       <= skf_pkg::RST_PROCESS_VAR;
			cw_q       <= skf_pkg::RST_MEASURE_VAR;
			x_q        <= '0;
			p_q        <= skf_pkg::VAR_W'(skf_pkg::RST_START_VAR);
			sat_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == skf_pkg::S_IDLE && s_tvalid) sat_q <= 1'b0;
			else if (state_q == skf_pkg::S_EST && t_over) sat_q <= 1'b1;
			else if (state_q == skf_pkg::S_AX && step_done && ax_over) sat_q <= 1'b1;

			if (out_load) begin
				x_q        <= xn_q;
				p_q        <= (p_next > (DW+1)'(skf_pkg::VAR_MAX)) ? skf_pkg::VAR_MAX
					: p_next[skf_pkg::VAR_W-1:0];
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					skf_pkg::REG_STATE_GAIN:   a_q  <= cfg_data[skf_pkg::COEF_W-1:0];
					skf_pkg::REG_NOISE_GAIN:   b_q  <= cfg_data[skf_pkg::COEF_W-1:0];
					skf_pkg::REG_MEASURE_GAIN: h_q  <= cfg_data[skf_pkg::COEF_W-1:0];
					skf_pkg::REG_PROCESS_VAR:  cu_q <= cfg_data;
					skf_pkg::REG_MEASURE_VAR:  cw_q <= cfg_data;
					skf_pkg::REG_START_VAR:    p_q  <= skf_pkg::VAR_W'(cfg_data);
					default: ;
				endcase
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// ---------------------------------------------------------------- assertions
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == skf_pkg::S_HP)
		else $error("accepted measurement did not start the gain products");

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == skf_pkg::S_DIV && div_done |-> quo_q <= skf_pkg::GAIN_ONE)
		else $error("gain above 1.0");

	a_var_factor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == skf_pkg::S_PEST |-> d_q <= skf_pkg::GAIN_ONE)
		else $error("variance factor above 1.0");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !m_tvalid_q || m_tready)
		else $error("result overwrote a pending transaction");

endmodule
